// File: rtl/core/bap_pkg.sv
// Shared constants, register codes and types for the block average pixelate core.
package bap_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;
  localparam int TILE_SIZE_DEF  = 3;
  localparam int OUT_DEPTH      = 4;
  localparam int CFG_DATA_W     = 16;
  localparam int SIZE_REG_W     = 12;
  localparam int POS_W          = 16;
  localparam int COLOR_W        = 8;

  typedef enum logic [1:0] {
    REG_REGION_WIDTH  = 2'd0,
    REG_REGION_HEIGHT = 2'd1,
    REG_ORIGIN_X      = 2'd2,
    REG_ORIGIN_Y      = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic                    valid;
    logic                    final_tile;
    logic signed [POS_W-1:0] tile_x;
    logic signed [POS_W-1:0] tile_y;
  } tile_ctl_t;

endpackage

// File: rtl/core/block_average_pixelate_core.sv
// Top level of the block average pixelate core: pixel stream in, tile averages out.
// A tile's result is registered in the sum stage, the average stage and the result queue before it is offered.
// Throughput: one pixel per cycle, set by the single accumulator RAM read-modify-write
// with one-entry forwarding; input stalls while four results are queued or in flight.
// Reset (synchronous, active high) sets width and height to 1, origins to 0, the position
// to the top left and empties the queue; the sum RAM is not cleared and needs no pass.
module block_average_pixelate_core #(
  parameter int MAX_WIDTH  = bap_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bap_pkg::MAX_HEIGHT_DEF,
  parameter int TILE_SIZE  = bap_pkg::TILE_SIZE_DEF,
  localparam int TWW = $clog2(TILE_SIZE + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [1:0]                           cfg_index,
  input  logic [bap_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bap_pkg::COLOR_W-1:0]          red,
  input  logic [bap_pkg::COLOR_W-1:0]          green,
  input  logic [bap_pkg::COLOR_W-1:0]          blue,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [bap_pkg::POS_W-1:0]     tile_x,
  output logic signed [bap_pkg::POS_W-1:0]     tile_y,
  output logic [TWW-1:0]                       tile_width,
  output logic [TWW-1:0]                       tile_height,
  output logic [bap_pkg::COLOR_W-1:0]          avg_red,
  output logic [bap_pkg::COLOR_W-1:0]          avg_green,
  output logic [bap_pkg::COLOR_W-1:0]          avg_blue,
  output logic                                 final_tile
);

  localparam int SW    = $clog2(TILE_SIZE * TILE_SIZE * 255 + 1);
  localparam int CNTW  = $clog2(TILE_SIZE * TILE_SIZE + 1);
  localparam int DEPTH = bap_pkg::OUT_DEPTH;
  localparam int QW    = 2 * bap_pkg::POS_W + 2 * TWW + 3 * bap_pkg::COLOR_W + 1;
  localparam int FCW   = $clog2(DEPTH + 1);
  localparam int TOTW  = FCW + 1;

  bap_pkg::tile_ctl_t          acc_ctl;
  bap_pkg::tile_ctl_t          avg_ctl;
  logic [TWW-1:0]              acc_tw;
  logic [TWW-1:0]              acc_th;
  logic [CNTW-1:0]             acc_cnt;
  logic [SW-1:0]               acc_red;
  logic [SW-1:0]               acc_green;
  logic [SW-1:0]               acc_blue;
  logic [TWW-1:0]              avg_tw;
  logic [TWW-1:0]              avg_th;
  logic [bap_pkg::COLOR_W-1:0] avg_r;
  logic [bap_pkg::COLOR_W-1:0] avg_g;
  logic [bap_pkg::COLOR_W-1:0] avg_b;
  logic                        accept;
  logic [QW-1:0]               q_in;
  logic [QW-1:0]               q_out;
  logic [FCW-1:0]              q_count;
  logic [TOTW-1:0]             pending;

  // Queued results plus finished tiles still in the pipeline bound the queue fill.
  assign pending  = TOTW'(q_count) + TOTW'(acc_ctl.valid) + TOTW'(avg_ctl.valid);
  assign in_stall = pending >= TOTW'(DEPTH);
  assign accept   = in_valid && !in_stall;

  bap_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .TILE_SIZE  (TILE_SIZE)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .ctl         (acc_ctl),
    .tile_width  (acc_tw),
    .tile_height (acc_th),
    .cnt         (acc_cnt),
    .sum_red     (acc_red),
    .sum_green   (acc_green),
    .sum_blue    (acc_blue)
  );

  bap_avg #(
    .TILE_SIZE (TILE_SIZE)
  ) u_avg (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (acc_ctl),
    .tw_in     (acc_tw),
    .th_in     (acc_th),
    .cnt       (acc_cnt),
    .sum_red   (acc_red),
    .sum_green (acc_green),
    .sum_blue  (acc_blue),
    .ctl_out   (avg_ctl),
    .tw_out    (avg_tw),
    .th_out    (avg_th),
    .avg_red   (avg_r),
    .avg_green (avg_g),
    .avg_blue  (avg_b)
  );

  assign q_in = {avg_ctl.tile_x, avg_ctl.tile_y, avg_tw, avg_th,
                 avg_r, avg_g, avg_b, avg_ctl.final_tile};

  bap_out_fifo #(
    .WIDTH (QW),
    .DEPTH (DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (avg_ctl.valid),
    .push_data (q_in),
    .pop       (out_valid && !out_stall),
    .out_valid (out_valid),
    .out_data  (q_out),
    .count     (q_count)
  );

  assign {tile_x, tile_y, tile_width, tile_height,
          avg_red, avg_green, avg_blue, final_tile} = q_out;

`ifndef SYNTH
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= TOTW'(DEPTH))
    else $error("More results outstanding than the queue can hold.");
`endif

endmodule

// File: rtl/core/bap_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module bap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/bap_accum.sv
// Configuration registers, raster position counters and the tile sum read-modify-write.
module bap_accum #(
  parameter int MAX_WIDTH  = bap_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bap_pkg::MAX_HEIGHT_DEF,
  parameter int TILE_SIZE  = bap_pkg::TILE_SIZE_DEF,
  localparam int SW   = $clog2(TILE_SIZE * TILE_SIZE * 255 + 1),
  localparam int TWW  = $clog2(TILE_SIZE + 1),
  localparam int CNTW = $clog2(TILE_SIZE * TILE_SIZE + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [1:0]                     cfg_index,
  input  logic [bap_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           accept,
  input  logic [bap_pkg::COLOR_W-1:0]    red,
  input  logic [bap_pkg::COLOR_W-1:0]    green,
  input  logic [bap_pkg::COLOR_W-1:0]    blue,
  output bap_pkg::tile_ctl_t             ctl,
  output logic [TWW-1:0]                 tile_width,
  output logic [TWW-1:0]                 tile_height,
  output logic [CNTW-1:0]                cnt,
  output logic [SW-1:0]                  sum_red,
  output logic [SW-1:0]                  sum_green,
  output logic [SW-1:0]                  sum_blue
);

  localparam int TILE_COLS = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
  localparam int AW  = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CI  = $clog2(MAX_WIDTH);
  localparam int RI  = $clog2(MAX_HEIGHT);
  localparam int MW  = $clog2(TILE_SIZE);
  localparam int EW  = 3 * SW;
  localparam int PW  = bap_pkg::POS_W;
  localparam int CLW = bap_pkg::COLOR_W;

  logic [bap_pkg::SIZE_REG_W-1:0] region_width;
  logic [bap_pkg::SIZE_REG_W-1:0] region_height;
  logic signed [PW-1:0]           origin_x;
  logic signed [PW-1:0]           origin_y;

  logic [CI-1:0] col;
  logic [RI-1:0] row;
  logic [MW-1:0] cmod;
  logic [MW-1:0] rmod;
  logic [AW-1:0] tc;
  logic [CI-1:0] sx;
  logic [RI-1:0] sy;

  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic           last_col;
  logic           last_row;
  logic           first_px;
  logic           done;
  logic [WW-1:0]  rem_w;
  logic [HW-1:0]  rem_h;
  logic [TWW-1:0] tw;
  logic [TWW-1:0] th;

  logic               b_valid;
  logic               b_first;
  logic               b_done;
  logic [AW-1:0]      b_addr;
  logic [CLW-1:0]     b_red;
  logic [CLW-1:0]     b_green;
  logic [CLW-1:0]     b_blue;
  logic               b_final;
  logic [PW-1:0]      b_x;
  logic [PW-1:0]      b_y;
  logic [TWW-1:0]     b_tw;
  logic [TWW-1:0]     b_th;

  logic               fwd_valid;
  logic [AW-1:0]      fwd_addr;
  logic [EW-1:0]      fwd_data;
  logic [EW-1:0]      rd_data;
  logic [EW-1:0]      old_entry;
  logic [EW-1:0]      new_entry;

  always_comb begin
    if (region_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(region_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(region_width);
    end
    if (region_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(region_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(region_height);
    end
  end

  assign last_col = (WW'(col) + WW'(1)) == w_eff;
  assign last_row = (HW'(row) + HW'(1)) == h_eff;
  assign first_px = (cmod == '0) && (rmod == '0);
  assign done     = (last_col || cmod == MW'(TILE_SIZE - 1)) &&
                    (last_row || rmod == MW'(TILE_SIZE - 1));
  assign rem_w    = w_eff - WW'(sx);
  assign rem_h    = h_eff - HW'(sy);
  assign tw       = (32'(rem_w) < TILE_SIZE) ? TWW'(rem_w) : TWW'(TILE_SIZE);
  assign th       = (32'(rem_h) < TILE_SIZE) ? TWW'(rem_h) : TWW'(TILE_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      region_width  <= bap_pkg::SIZE_REG_W'(1);
      region_height <= bap_pkg::SIZE_REG_W'(1);
      origin_x      <= '0;
      origin_y      <= '0;
      col           <= '0;
      row           <= '0;
      cmod          <= '0;
      rmod          <= '0;
      tc            <= '0;
      sx            <= '0;
      sy            <= '0;
    end else if (cfg_wr_en) begin
      unique case (bap_pkg::reg_index_t'(cfg_index))
        bap_pkg::REG_REGION_WIDTH: begin
          region_width <= cfg_data[bap_pkg::SIZE_REG_W-1:0];
        end
        bap_pkg::REG_REGION_HEIGHT: begin
          region_height <= cfg_data[bap_pkg::SIZE_REG_W-1:0];
        end
        bap_pkg::REG_ORIGIN_X: begin
          origin_x <= cfg_data[PW-1:0];
        end
        bap_pkg::REG_ORIGIN_Y: begin
          origin_y <= cfg_data[PW-1:0];
        end
        default: begin
        end
      endcase
      if (bap_pkg::reg_index_t'(cfg_index) == bap_pkg::REG_REGION_WIDTH ||
          bap_pkg::reg_index_t'(cfg_index) == bap_pkg::REG_REGION_HEIGHT) begin
        col  <= '0;
        row  <= '0;
        cmod <= '0;
        rmod <= '0;
        tc   <= '0;
        sx   <= '0;
        sy   <= '0;
      end
    end else if (accept) begin
      if (last_col) begin
        col  <= '0;
        cmod <= '0;
        tc   <= '0;
        sx   <= '0;
        if (last_row) begin
          row  <= '0;
          rmod <= '0;
          sy   <= '0;
        end else begin
          row <= row + RI'(1);
          if (rmod == MW'(TILE_SIZE - 1)) begin
            rmod <= '0;
            sy   <= sy + RI'(TILE_SIZE);
          end else begin
            rmod <= rmod + MW'(1);
          end
        end
      end else begin
        col <= col + CI'(1);
        if (cmod == MW'(TILE_SIZE - 1)) begin
          cmod <= '0;
          tc   <= tc + AW'(1);
          sx   <= sx + CI'(TILE_SIZE);
        end else begin
          cmod <= cmod + MW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      b_valid   <= accept;
      fwd_valid <= b_valid;
    end
    if (accept) begin
      b_first <= first_px;
      b_done  <= done;
      b_addr  <= tc;
      b_red   <= red;
      b_green <= green;
      b_blue  <= blue;
      b_final <= last_col && last_row;
      b_x     <= origin_x + PW'(sx);
      b_y     <= origin_y + PW'(sy);
      b_tw    <= tw;
      b_th    <= th;
    end
    fwd_addr <= b_addr;
    fwd_data <= new_entry;
  end

  // The entry written at the edge that issued this read is not yet in the RAM output.
  assign old_entry = (fwd_valid && fwd_addr == b_addr) ? fwd_data : rd_data;

  always_comb begin
    if (b_first) begin
      new_entry = {SW'(b_red), SW'(b_green), SW'(b_blue)};
    end else begin
      new_entry = {old_entry[3*SW-1:2*SW] + SW'(b_red),
                   old_entry[2*SW-1:SW]   + SW'(b_green),
                   old_entry[SW-1:0]      + SW'(b_blue)};
    end
  end

  bap_ram #(
    .WIDTH (EW),
    .DEPTH (TILE_COLS)
  ) u_sums (
    .clk     (clk),
    .wr_en   (b_valid),
    .wr_addr (b_addr),
    .wr_data (new_entry),
    .rd_en   (accept),
    .rd_addr (tc),
    .rd_data (rd_data)
  );

  assign ctl.valid      = b_valid && b_done;
  assign ctl.final_tile = b_final;
  assign ctl.tile_x     = b_x;
  assign ctl.tile_y     = b_y;
  assign tile_width     = b_tw;
  assign tile_height    = b_th;
  assign cnt            = CNTW'(b_tw) * CNTW'(b_th);
  assign sum_red        = new_entry[3*SW-1:2*SW];
  assign sum_green      = new_entry[2*SW-1:SW];
  assign sum_blue       = new_entry[SW-1:0];

`ifndef SYNTH
  a_pos_in_region: assert property (@(posedge clk) disable iff (rst)
    accept |-> (WW'(col) < w_eff) && (HW'(row) < h_eff))
    else $error("Pixel position lies outside the region.");

  a_done_count: assert property (@(posedge clk) disable iff (rst)
    ctl.valid |-> (b_tw != '0) && (b_th != '0))
    else $error("Finished tile has zero size.");
`endif

endmodule

// File: rtl/core/bap_avg.sv
// Tile average by multiplication with a reciprocal chosen by pixel count.
module bap_avg #(
  parameter int TILE_SIZE = bap_pkg::TILE_SIZE_DEF,
  localparam int SW   = $clog2(TILE_SIZE * TILE_SIZE * 255 + 1),
  localparam int TWW  = $clog2(TILE_SIZE + 1),
  localparam int CNTW = $clog2(TILE_SIZE * TILE_SIZE + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bap_pkg::tile_ctl_t          ctl_in,
  input  logic [TWW-1:0]              tw_in,
  input  logic [TWW-1:0]              th_in,
  input  logic [CNTW-1:0]             cnt,
  input  logic [SW-1:0]               sum_red,
  input  logic [SW-1:0]               sum_green,
  input  logic [SW-1:0]               sum_blue,
  output bap_pkg::tile_ctl_t          ctl_out,
  output logic [TWW-1:0]              tw_out,
  output logic [TWW-1:0]              th_out,
  output logic [bap_pkg::COLOR_W-1:0] avg_red,
  output logic [bap_pkg::COLOR_W-1:0] avg_green,
  output logic [bap_pkg::COLOR_W-1:0] avg_blue
);

  localparam int K    = SW + $clog2(TILE_SIZE * TILE_SIZE);
  localparam int RW   = K + 1;
  localparam int PW   = SW + RW;
  localparam int NREC = 2 ** CNTW;
  localparam int CLW  = bap_pkg::COLOR_W;

  logic [RW-1:0] recip_tab [NREC];
  logic [RW-1:0] recip;
  logic [PW-1:0] prod_red;
  logic [PW-1:0] prod_green;
  logic [PW-1:0] prod_blue;

  // ceil(2^K / d) makes the truncated quotient exact for every tile sum and pixel count in use.
  for (genvar d = 0; d < NREC; d++) begin : g_recip
    localparam longint DV  = (d == 0) ? 1 : d;
    localparam longint RV  = ((64'd1 << K) + DV - 1) / DV;
    assign recip_tab[d] = RW'(RV);
  end

  assign recip = recip_tab[cnt];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.final_tile <= ctl_in.final_tile;
    ctl_out.tile_x     <= ctl_in.tile_x;
    ctl_out.tile_y     <= ctl_in.tile_y;
    tw_out             <= tw_in;
    th_out             <= th_in;
    prod_red           <= PW'(sum_red) * PW'(recip);
    prod_green         <= PW'(sum_green) * PW'(recip);
    prod_blue          <= PW'(sum_blue) * PW'(recip);
  end

  assign avg_red   = prod_red[K+CLW-1:K];
  assign avg_green = prod_green[K+CLW-1:K];
  assign avg_blue  = prod_blue[K+CLW-1:K];

`ifndef SYNTH
  a_avg_range: assert property (@(posedge clk) disable iff (rst)
    ctl_out.valid |-> (prod_red[PW-1:K+CLW] == '0) && (prod_green[PW-1:K+CLW] == '0) &&
                      (prod_blue[PW-1:K+CLW] == '0))
    else $error("Tile average exceeds the color range.");
`endif

endmodule

// File: rtl/core/bap_out_fifo.sv
// Small result queue that decouples the output handshake from the pipeline.
module bap_out_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    head;
  logic [AW-1:0]    tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == AW'(DEPTH - 1)) ? '0 : tail + AW'(1);
      end
      if (pop) begin
        head <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
    if (push) begin
      slots[tail] <= push_data;
    end
  end

  assign out_valid = count != '0;
  assign out_data  = slots[head];

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != CW'(DEPTH)) || pop)
    else $error("Result queue written while full.");
`endif

endmodule

// File: tb/tile_average_monitor.sv
// Tile average predictor and result comparator for the block average pixelate core.
module tile_average_monitor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_index,
  input  logic [bap_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [bap_pkg::COLOR_W-1:0]         red,
  input  logic [bap_pkg::COLOR_W-1:0]         green,
  input  logic [bap_pkg::COLOR_W-1:0]         blue,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [bap_pkg::POS_W-1:0]    tile_x,
  input  logic signed [bap_pkg::POS_W-1:0]    tile_y,
  input  logic [1:0]                          tile_width,
  input  logic [1:0]                          tile_height,
  input  logic [bap_pkg::COLOR_W-1:0]         avg_red,
  input  logic [bap_pkg::COLOR_W-1:0]         avg_green,
  input  logic [bap_pkg::COLOR_W-1:0]         avg_blue,
  input  logic                                final_tile,
  output int                                  fail_count,
  output int                                  tiles_checked,
  output int                                  pending_tiles
);

  localparam int TS        = bap_pkg::TILE_SIZE_DEF;
  localparam int TILE_COLS = (bap_pkg::MAX_WIDTH_DEF + TS - 1) / TS;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [1:0]         w;
    logic [1:0]         h;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic               last;
  } tile_avg_t;

  logic [11:0] width_reg;
  logic [11:0] height_reg;
  logic [15:0] org_x;
  logic [15:0] org_y;
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned red_sum [TILE_COLS];
  int unsigned green_sum [TILE_COLS];
  int unsigned blue_sum [TILE_COLS];
  tile_avg_t   tile_queue [$];
  int          mismatches = 0;
  int          checked = 0;

  function automatic int unsigned clamp_size(logic [11:0] v, int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic void absorb_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned w, h, col, row, tcol, sx, sy, tw, th, cnt;
    bit right_edge, bottom_edge;
    tile_avg_t t;
    w = clamp_size(width_reg, bap_pkg::MAX_WIDTH_DEF);
    h = clamp_size(height_reg, bap_pkg::MAX_HEIGHT_DEF);
    col = col_pos;
    row = row_pos;
    if (col >= w) col = w - 1;
    if (row >= h) row = h - 1;
    tcol = col / TS;
    if (tcol >= TILE_COLS) tcol = TILE_COLS - 1;
    sx = col - col % TS;
    sy = row - row % TS;
    // The top-left pixel of a tile starts a fresh sum in its column entry.
    if (col % TS == 0 && row % TS == 0) begin
      red_sum[tcol] = r;
      green_sum[tcol] = g;
      blue_sum[tcol] = b;
    end else begin
      red_sum[tcol] += r;
      green_sum[tcol] += g;
      blue_sum[tcol] += b;
    end
    right_edge = (col + 1 == w);
    bottom_edge = (row + 1 == h);
    if ((right_edge || col % TS == TS - 1) && (bottom_edge || row % TS == TS - 1)) begin
      tw = (w - sx < TS) ? w - sx : TS;
      th = (h - sy < TS) ? h - sy : TS;
      cnt = tw * th;
      t.x = org_x + 16'(sx);
      t.y = org_y + 16'(sy);
      t.w = 2'(tw);
      t.h = 2'(th);
      t.r = 8'(red_sum[tcol] / cnt);
      t.g = 8'(green_sum[tcol] / cnt);
      t.b = 8'(blue_sum[tcol] / cnt);
      t.last = right_edge && bottom_edge;
      tile_queue.push_back(t);
    end
    if (right_edge) begin
      col_pos = 0;
      row_pos = bottom_edge ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end
  endfunction

  function automatic void check_field(string label, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: tile %s mismatch, expected %0d, got %0d", $time, label, want, got);
    end
  endfunction

  always @(posedge clk) begin
    tile_avg_t want;
    if (rst) begin
      width_reg = 12'd1;
      height_reg = 12'd1;
      org_x = '0;
      org_y = '0;
      col_pos = 0;
      row_pos = 0;
      tile_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (tile_queue.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected tile result, expected none, got x=%0d y=%0d",
                   $time, tile_x, tile_y);
        end else begin
          want = tile_queue.pop_front();
          checked++;
          check_field("x", want.x, tile_x);
          check_field("y", want.y, tile_y);
          check_field("width", want.w, tile_width);
          check_field("height", want.h, tile_height);
          check_field("red", want.r, avg_red);
          check_field("green", want.g, avg_green);
          check_field("blue", want.b, avg_blue);
          check_field("final", want.last, final_tile);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          bap_pkg::REG_REGION_WIDTH: begin
            width_reg = cfg_data[bap_pkg::SIZE_REG_W-1:0];
            col_pos = 0;
            row_pos = 0;
          end
          bap_pkg::REG_REGION_HEIGHT: begin
            height_reg = cfg_data[bap_pkg::SIZE_REG_W-1:0];
            col_pos = 0;
            row_pos = 0;
          end
          bap_pkg::REG_ORIGIN_X: begin
            org_x = cfg_data;
          end
          bap_pkg::REG_ORIGIN_Y: begin
            org_y = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) absorb_pixel(red, green, blue);
    end
    fail_count <= mismatches;
    tiles_checked <= checked;
    pending_tiles <= tile_queue.size();
  end

endmodule

// File: tb/block_average_pixelate_core_test.sv
// Stimulus, handshake pressure and verdict for the block average pixelate core.
module block_average_pixelate_core_test;

  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int SMALL_PIXELS = 1560;
  localparam int ROW_PIXELS   = 300;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         red = '0;
  logic [7:0]         green = '0;
  logic [7:0]         blue = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] tile_x;
  logic signed [15:0] tile_y;
  logic [1:0]         tile_width;
  logic [1:0]         tile_height;
  logic [7:0]         avg_red;
  logic [7:0]         avg_green;
  logic [7:0]         avg_blue;
  logic               final_tile;

  int fail_count;
  int tiles_checked;
  int pending_tiles;
  int send_idle_pct = 26;
  int recv_stall_pct = 65;
  int pixels_sent = 0;
  int regions_set = 0;
  int quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  block_average_pixelate_core u_dut (.*);

  tile_average_monitor u_monitor (.*);

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("block_average_pixelate_core_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_level();
    int unsigned k;
    k = $urandom_range(7);
    if (k == 0) return 8'h00;
    if (k == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] pick_origin();
    int unsigned k;
    k = $urandom_range(7);
    if (k == 0) return 16'h7FFF;
    if (k == 1) return 16'h8000;
    if (k == 2) return 16'h0000;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  // The upper bits of a size write lie outside the register and must be ignored.
  function automatic logic [15:0] pick_size(int unsigned hi);
    logic [15:0] base;
    base = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(hi, 1));
    return base | 16'($urandom_range(15) << 12);
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic feed_pixels(input int count);
    for (int i = 0; i < count; i++) send_pixel(pick_level(), pick_level(), pick_level());
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_tiles != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input bap_pkg::reg_index_t idx, input logic [15:0] value,
                           input bit more);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (!more) cfg_wr_en <= 1'b0;
  endtask

  task automatic set_region(input logic [15:0] w, input logic [15:0] h,
                            input logic [15:0] ox, input logic [15:0] oy);
    write_reg(bap_pkg::REG_REGION_WIDTH, w, 1'b1);
    write_reg(bap_pkg::REG_REGION_HEIGHT, h, 1'b1);
    write_reg(bap_pkg::REG_ORIGIN_X, ox, 1'b1);
    write_reg(bap_pkg::REG_ORIGIN_Y, oy, 1'b0);
    regions_set++;
  endtask

  task automatic set_origin(input logic [15:0] ox, input logic [15:0] oy);
    write_reg(bap_pkg::REG_ORIGIN_X, ox, 1'b1);
    write_reg(bap_pkg::REG_ORIGIN_Y, oy, 1'b0);
  endtask

  initial begin
    logic [15:0] w_val, h_val;
    int area, style, split, small_start;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // After reset the region is a single pixel, so every pixel is a final tile.
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    settle();
    set_region(16'd3, 16'd3, 16'h0000, 16'h0000);
    for (int i = 0; i < 9; i++) send_pixel(8'hFF, 8'h00, 8'(255 - i));
    settle();
    // Origins at the signed extremes make the second tile column wrap.
    set_region(16'd4, 16'd2, 16'h7FFF, 16'h8000);
    feed_pixels(8);
    settle();
    set_region(16'd0, 16'd2, 16'hFFFF, 16'h0000);
    feed_pixels(2);
    settle();

    // Oversized width saturates to the maximum; the start of one long row is sent.
    set_region(16'h0FFF, 16'd1, 16'h8000, 16'h7FFF);
    feed_pixels(ROW_PIXELS);
    settle();
    // Tall region left unfinished; the next size write starts over.
    set_region(16'h0000, 16'hFFFF, 16'h0000, 16'h7FFF);
    feed_pixels(10);
    settle();

    small_start = pixels_sent;
    while (pixels_sent - small_start < SMALL_PIXELS) begin
      if (pixels_sent - small_start >= 2 * SMALL_PIXELS / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (pixels_sent - small_start >= SMALL_PIXELS / 3) begin
        send_idle_pct = 65;
        recv_stall_pct = 26;
      end
      w_val = pick_size(10);
      h_val = pick_size(8);
      area = ((w_val[11:0] == 0) ? 1 : int'(w_val[11:0])) *
             ((h_val[11:0] == 0) ? 1 : int'(h_val[11:0]));
      set_region(w_val, h_val, pick_origin(), pick_origin());
      style = $urandom_range(9);
      split = $urandom_range(area - 1);
      if (style == 0) begin
        feed_pixels(split);
      end else if (style == 1) begin
        feed_pixels(split);
        settle();
        set_origin(pick_origin(), pick_origin());
        feed_pixels(area - split);
      end else if (style == 2) begin
        feed_pixels(split);
        settle();
        feed_pixels(area - split);
      end else begin
        feed_pixels(area);
      end
      settle();
    end

    $display("Sent %0d pixels over %0d region settings and checked %0d tile results.",
             pixels_sent, regions_set, tiles_checked);
    $display("Regions ran from one pixel to part of an oversized row, under stalls on both sides.");
    if (fail_count == 0 && pending_tiles == 0) begin
      $display("block_average_pixelate_core_test passed");
    end else begin
      $display("block_average_pixelate_core_test failed");
    end
    $finish;
  end

endmodule
